@@ hdl/tgarle_pkg.sv @@
package tgarle_pkg;

  // field and register widths
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PIXEL_W     = 32;
  localparam int unsigned RUN_W       = 8;
  localparam int unsigned BPP_W       = 3;
  localparam int unsigned DIM_W       = 16;
  localparam int unsigned COUNT_W     = 2 * DIM_W;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // result queue depth
  localparam int unsigned DEFAULT_FIFO_DEPTH = 2;

  // register reset values
  localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;
  localparam logic [DIM_W-1:0] DIM_RESET = 16'd1;

  // pixel sizes in bytes
  localparam logic [2:0] BPP_SMALL = 3'd3;
  localparam logic [2:0] BPP_LARGE = 3'd4;

  // packet header layout
  localparam int unsigned PKT_TYPE_BIT   = 7;
  localparam logic [6:0]  PKT_COUNT_MASK = 7'h7f;

  // cycles the front holds off after a register write
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BPP    = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_index_e;

  // finished pixel from the byte parser
  typedef struct packed {
    logic               pix_done;
    logic               repeat_pkt;
    logic [RUN_W-1:0]   packet_left;
    logic [PIXEL_W-1:0] pixel;
  } pix_evt_t;

  // status from the pixel counter back to the parser
  typedef struct packed {
    logic blocked;
    logic four_bytes;
  } count_stat_t;

  // one result item
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_value;
    logic [RUN_W-1:0]   run_length;
    logic               image_done;
    logic               run_clipped;
  } result_t;

endpackage

@@ hdl/tga_rle_pixel_decoder.sv @@
// TGA run-length pixel decoder for 24 and 32 bit true-colour images. Bytes of the RLE pixel
// section go in one per cycle on push/full; each finished pixel comes out of a small result
// queue on empty/pop with its value (first byte in bits 7:0), its run length, and flags for
// image complete and run clipped at the image end. start_image on a byte restarts the image
// and that byte is read as a packet header; bytes past the last pixel are dropped. The
// parser and the pixel counter take one byte every cycle while full is low, with no
// bubbles, so a result goes into the queue in the same cycle as the last byte of its pixel.
// After any register write full stays high while the pixel total (width times height, one
// multiplier) and the remaining count are recomputed.
module tga_rle_pixel_decoder #(
  parameter int unsigned FIFO_DEPTH = tgarle_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tgarle_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [tgarle_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                               push,
  output logic                               full,
  input  logic [tgarle_pkg::BYTE_W-1:0]      data_byte_i,
  input  logic                               start_image_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [tgarle_pkg::PIXEL_W-1:0]     pixel_value_o,
  output logic [tgarle_pkg::RUN_W-1:0]       run_length_o,
  output logic                               image_done_o,
  output logic                               run_clipped_o
);
  import tgarle_pkg::*;

  logic        accept;
  logic        fifo_full;
  logic        cfg_busy;
  logic        res_valid;
  logic        pop_ok;
  pix_evt_t    evt;
  count_stat_t stat;
  result_t     res;
  result_t     head;

  // input item taken when the queue has room and the counter is settled
  assign full   = fifo_full || cfg_busy;
  assign accept = push && !full;
  assign pop_ok = pop && !empty;

  tgarle_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .start_i  (start_image_i),
    .byte_i   (data_byte_i),
    .stat_i   (stat),
    .evt_o    (evt)
  );

  tgarle_count u_count (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .start_i     (start_image_i),
    .evt_i       (evt),
    .stat_o      (stat),
    .busy_o      (cfg_busy),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tgarle_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (fifo_full),
    .pop_i   (pop_ok),
    .empty_o (empty),
    .data_o  (head)
  );

  // result ports from the queue head
  assign pixel_value_o = head.pixel_value;
  assign run_length_o  = head.run_length;
  assign image_done_o  = head.image_done;
  assign run_clipped_o = head.run_clipped;

endmodule

@@ hdl/tgarle_parse.sv @@
module tgarle_parse (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic                           start_i,
  input  logic [tgarle_pkg::BYTE_W-1:0]  byte_i,
  input  tgarle_pkg::count_stat_t        stat_i,
  output tgarle_pkg::pix_evt_t           evt_o
);
  import tgarle_pkg::*;

  logic               expect_q, expect_d;
  logic               repeat_q, repeat_d;
  logic [RUN_W-1:0]   left_q, left_d;
  logic [1:0]         bip_q, bip_d;
  logic [PIXEL_W-1:0] asm_q, asm_d;

  // state as seen after an optional image restart
  logic               expect_b;
  logic               repeat_b;
  logic [RUN_W-1:0]   left_b;
  logic [1:0]         bip_b;
  logic [PIXEL_W-1:0] asm_b;

  logic [PIXEL_W-1:0] merged;
  logic [2:0]         next_bip;
  logic [2:0]         bpp_lim;
  logic [RUN_W-1:0]   left_dec;

  // start of image clears the parser before the byte is taken
  always_comb begin
    if (start_i) begin
      expect_b = 1'b1;
      repeat_b = 1'b0;
      left_b   = '0;
      bip_b    = '0;
      asm_b    = '0;
    end else begin
      expect_b = expect_q;
      repeat_b = repeat_q;
      left_b   = left_q;
      bip_b    = bip_q;
      asm_b    = asm_q;
    end
  end

  // byte placement and pixel size
  assign merged   = asm_b | (PIXEL_W'(byte_i) << {bip_b, 3'b000});
  assign next_bip = {1'b0, bip_b} + 3'd1;
  assign bpp_lim  = stat_i.four_bytes ? BPP_LARGE : BPP_SMALL;
  assign left_dec = (left_b != '0) ? left_b - RUN_W'(1) : '0;

  // header and pixel byte handling
  always_comb begin
    expect_d          = expect_q;
    repeat_d          = repeat_q;
    left_d            = left_q;
    bip_d             = bip_q;
    asm_d             = asm_q;
    evt_o.pix_done    = 1'b0;
    evt_o.repeat_pkt  = repeat_b;
    evt_o.packet_left = left_b;
    evt_o.pixel       = merged;
    if (accept_i) begin
      expect_d = expect_b;
      repeat_d = repeat_b;
      left_d   = left_b;
      bip_d    = bip_b;
      asm_d    = asm_b;
      if (!stat_i.blocked) begin
        if (expect_b) begin
          repeat_d = byte_i[PKT_TYPE_BIT];
          left_d   = {1'b0, byte_i[6:0] & PKT_COUNT_MASK} + RUN_W'(1);
          expect_d = 1'b0;
          bip_d    = '0;
          asm_d    = '0;
        end else if (next_bip < bpp_lim) begin
          bip_d = next_bip[1:0];
          asm_d = merged;
        end else begin
          bip_d          = '0;
          asm_d          = '0;
          evt_o.pix_done = 1'b1;
          if (repeat_b) begin
            left_d   = '0;
            expect_d = 1'b1;
          end else begin
            left_d = left_dec;
            if (left_dec == '0) begin
              expect_d = 1'b1;
            end
          end
        end
      end
    end
  end

  // parser registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q <= 1'b1;
      repeat_q <= 1'b0;
      left_q   <= '0;
      bip_q    <= '0;
      asm_q    <= '0;
    end else begin
      expect_q <= expect_d;
      repeat_q <= repeat_d;
      left_q   <= left_d;
      bip_q    <= bip_d;
      asm_q    <= asm_d;
    end
  end

`ifndef SYNTHESIS
  a_pix_needs_pixel_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_o.pix_done |-> (accept_i && !start_i && !stat_i.blocked))
    else $error("pixel finished without a pixel byte");
  a_header_opens_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !stat_i.blocked && expect_b) |=> (!expect_q && bip_q == '0 && left_q != '0))
    else $error("header did not open a packet");
  a_repeat_closes_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_o.pix_done && evt_o.repeat_pkt) |=> expect_q)
    else $error("repeat packet did not close after its pixel");
`endif

endmodule

@@ hdl/tgarle_count.sv @@
module tgarle_count (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tgarle_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [tgarle_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                               accept_i,
  input  logic                               start_i,
  input  tgarle_pkg::pix_evt_t               evt_i,
  output tgarle_pkg::count_stat_t            stat_o,
  output logic                               busy_o,
  output logic                               res_valid_o,
  output tgarle_pkg::result_t                res_o
);
  import tgarle_pkg::*;

  logic [BPP_W-1:0]   bpp_q, bpp_d;
  logic [DIM_W-1:0]   width_q, width_d;
  logic [DIM_W-1:0]   height_q, height_d;
  logic [COUNT_W-1:0] total_q, total_d;
  logic [COUNT_W-1:0] pdone_q, pdone_d;
  logic [COUNT_W-1:0] remain_q, remain_d;
  logic               finished_q, finished_d;
  logic [1:0]         settle_q, settle_d;

  logic [RUN_W-1:0]   n_pix;
  logic               rem_narrow;
  logic               n_gt;
  logic               n_ge;
  logic [RUN_W-1:0]   run;
  logic               clipped;

  // register writes
  always_comb begin
    bpp_d    = bpp_q;
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BPP:    bpp_d    = cfg_wdata_i[BPP_W-1:0];
        CFG_WIDTH:  width_d  = cfg_wdata_i[DIM_W-1:0];
        CFG_HEIGHT: height_d = cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // pixel total, one multiply per cycle
  assign total_d = COUNT_W'(width_q) * COUNT_W'(height_q);

  // settle counter after a register write
  always_comb begin
    if (cfg_we_i) begin
      settle_d = SETTLE_CYCLES;
    end else if (settle_q != '0) begin
      settle_d = settle_q - 2'd1;
    end else begin
      settle_d = settle_q;
    end
  end

  assign busy_o            = (settle_q != '0);
  assign stat_o.four_bytes = (bpp_q > BPP_W'(BPP_SMALL));
  assign stat_o.blocked    = start_i ? (total_q == '0) : (finished_q || remain_q == '0);

  // run length against the pixels still to come
  assign n_pix      = evt_i.repeat_pkt ? evt_i.packet_left : RUN_W'(1);
  assign rem_narrow = (remain_q[COUNT_W-1:RUN_W] == '0);
  assign n_gt       = rem_narrow && (n_pix > remain_q[RUN_W-1:0]);
  assign n_ge       = rem_narrow && (n_pix >= remain_q[RUN_W-1:0]);
  assign run        = n_gt ? remain_q[RUN_W-1:0] : n_pix;
  assign clipped    = evt_i.repeat_pkt ? n_gt :
                      (evt_i.packet_left > RUN_W'(1) && remain_q == COUNT_W'(1));

  // pixel accounting
  always_comb begin
    pdone_d    = pdone_q;
    remain_d   = remain_q;
    finished_d = finished_q;
    if (accept_i && start_i) begin
      pdone_d    = '0;
      remain_d   = total_q;
      finished_d = 1'b0;
    end else if (accept_i && evt_i.pix_done) begin
      pdone_d    = pdone_q + COUNT_W'(run);
      remain_d   = remain_q - COUNT_W'(run);
      finished_d = finished_q | n_ge;
    end else if (settle_q == 2'd1) begin
      remain_d = (total_q > pdone_q) ? total_q - pdone_q : '0;
    end
  end

  // result item
  assign res_valid_o       = accept_i && evt_i.pix_done;
  assign res_o.pixel_value = evt_i.pixel;
  assign res_o.run_length  = run;
  assign res_o.image_done  = n_ge;
  assign res_o.run_clipped = clipped;

  // counter and register state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q      <= BPP_RESET;
      width_q    <= DIM_RESET;
      height_q   <= DIM_RESET;
      total_q    <= COUNT_W'(1);
      pdone_q    <= '0;
      remain_q   <= COUNT_W'(1);
      finished_q <= 1'b0;
      settle_q   <= '0;
    end else begin
      bpp_q      <= bpp_d;
      width_q    <= width_d;
      height_q   <= height_d;
      total_q    <= total_d;
      pdone_q    <= pdone_d;
      remain_q   <= remain_d;
      finished_q <= finished_d;
      settle_q   <= settle_d;
    end
  end

`ifndef SYNTHESIS
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.run_length != '0))
    else $error("result with zero run length");
  a_clip_ends_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.run_clipped) |-> res_o.image_done)
    else $error("clipped run did not finish the image");
  a_done_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.image_done) |=> (finished_q && remain_q == '0))
    else $error("finished image still open");
`endif

endmodule

@@ hdl/tgarle_fifo.sv @@
module tgarle_fifo #(
  parameter int unsigned DEPTH = tgarle_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tgarle_pkg::result_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output tgarle_pkg::result_t data_o
);
  import tgarle_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  result_t          mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);

  // pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != CNT_W'(DEPTH)))
    else $error("item pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("item popped from an empty queue");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("queue level did not grow on push");
`endif

endmodule

@@ verif/tga_rle_pixel_decoder_tb.sv @@
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_tb;
  import tgarle_pkg::*;

  // pixel predictor and store of expected pixel runs
  class pixel_scoreboard;
    // register copies
    bit [BPP_W-1:0] bpp_reg;
    bit [DIM_W-1:0] width_reg;
    bit [DIM_W-1:0] height_reg;

    // decoder state copies
    bit             want_header;
    bit             repeat_pkt;
    bit [7:0]       pkt_left;
    bit [1:0]       byte_idx;
    bit [31:0]      assembly;
    bit [31:0]      done_count;
    bit             finished;

    result_t        runs_q[$];
    int unsigned    errors;

    function new();
      bpp_reg    = BPP_RESET;
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      errors     = 0;
      clear_image();
    endfunction

    function void clear_image();
      want_header = 1'b1;
      repeat_pkt  = 1'b0;
      pkt_left    = '0;
      byte_idx    = '0;
      assembly    = '0;
      done_count  = '0;
      finished    = 1'b0;
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    function int unsigned pending();
      return runs_q.size();
    endfunction

    function void write_reg(cfg_index_e idx, bit [DIM_W-1:0] value);
      case (idx)
        CFG_BPP:    bpp_reg = value[BPP_W-1:0];
        CFG_WIDTH:  width_reg = value;
        CFG_HEIGHT: height_reg = value;
        default: ;
      endcase
    endfunction

    function bit [31:0] image_pixels();
      return 32'(width_reg) * 32'(height_reg);
    endfunction

    // one accepted byte, may finish a pixel run
    function void note_byte(bit [7:0] b, bit start);
      int unsigned size;
      int unsigned nxt;
      bit [31:0]   total;
      bit [31:0]   remaining;
      bit [31:0]   run;
      bit          clipped;
      result_t     res;
      size    = (bpp_reg <= BPP_SMALL) ? 3 : 4;
      total   = image_pixels();
      clipped = 1'b0;
      if (start) clear_image();
      if (finished || done_count >= total) return;

      // packet header
      if (want_header) begin
        repeat_pkt  = b[PKT_TYPE_BIT];
        pkt_left    = 8'(b[6:0] & PKT_COUNT_MASK) + 8'd1;
        want_header = 1'b0;
        byte_idx    = '0;
        assembly    = '0;
        return;
      end

      // pixel byte, first byte lowest
      assembly = assembly | (32'(b) << (8 * byte_idx));
      nxt = byte_idx + 1;
      if (nxt < size) begin
        byte_idx = 2'(nxt);
        return;
      end
      byte_idx = '0;

      // finished pixel
      remaining = total - done_count;
      if (repeat_pkt) begin
        run = 32'(pkt_left);
        if (run > remaining) begin
          run     = remaining;
          clipped = 1'b1;
        end
        pkt_left    = '0;
        want_header = 1'b1;
      end else begin
        run = 32'd1;
        if (pkt_left > 8'd1 && remaining == 32'd1) clipped = 1'b1;
        pkt_left = (pkt_left > 0) ? pkt_left - 8'd1 : 8'd0;
        if (pkt_left == 0) want_header = 1'b1;
      end
      done_count = done_count + run;
      if (done_count >= total) finished = 1'b1;

      res.pixel_value = assembly;
      res.run_length  = run[7:0];
      res.image_done  = finished;
      res.run_clipped = clipped;
      runs_q.push_back(res);
      assembly = '0;
    endfunction

    // compare one popped run with the oldest prediction
    task check_result(result_t got);
      result_t want;
      if (runs_q.size() == 0) begin
        report($sformatf("unexpected run pixel=%h len=%0d", got.pixel_value, got.run_length));
        return;
      end
      want = runs_q.pop_front();
      if (got.pixel_value !== want.pixel_value)
        report($sformatf("pixel_value got %h want %h", got.pixel_value, want.pixel_value));
      if (got.run_length !== want.run_length)
        report($sformatf("run_length got %0d want %0d", got.run_length, want.run_length));
      if (got.image_done !== want.image_done)
        report($sformatf("image_done got %b want %b", got.image_done, want.image_done));
      if (got.run_clipped !== want.run_clipped)
        report($sformatf("run_clipped got %b want %b", got.run_clipped, want.run_clipped));
    endtask
  endclass

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_WAIT    = 6;
  localparam int unsigned ITEM_GOAL      = 1200;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_index_e            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  push;
  logic                  full;
  logic [BYTE_W-1:0]     data_byte;
  logic                  start_image;
  logic                  empty;
  logic                  pop;
  logic [PIXEL_W-1:0]    pixel_value;
  logic [RUN_W-1:0]      run_length;
  logic                  image_done;
  logic                  run_clipped;

  pixel_scoreboard board;
  bit              send_idle;
  bit              recv_idle;
  int unsigned     items_sent;
  int unsigned     stall_cycles;

  tga_rle_pixel_decoder i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .push          (push),
    .full          (full),
    .data_byte_i   (data_byte),
    .start_image_i (start_image),
    .empty         (empty),
    .pop           (pop),
    .pixel_value_o (pixel_value),
    .run_length_o  (run_length),
    .image_done_o  (image_done),
    .run_clipped_o (run_clipped)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tga_rle_pixel_decoder_tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // push one byte, called just after a falling edge
  task automatic send_byte(input logic [7:0] b, input logic start);
    int unsigned gap;
    bit          taken;
    gap = send_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push        = 1'b1;
    data_byte   = b;
    start_image = start;
    taken       = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !full;
      @(negedge clk);
    end
    board.note_byte(b, start);
    items_sent++;
  endtask

  // drain all runs, then let the pipeline settle
  task automatic wait_idle();
    push = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    board.write_reg(idx, value);
  endtask

  task automatic configure(input int unsigned bpp, input int unsigned w, input int unsigned h);
    write_reg(CFG_BPP, CFG_DATA_W'(bpp));
    write_reg(CFG_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
  endtask

  // one image of random packets, with some noise and cut-off streams
  task automatic send_image();
    int unsigned goal;
    int unsigned sent;
    int unsigned used;
    int unsigned budget;
    int unsigned n_pix;
    int unsigned size;
    logic [7:0]  hdr;
    bit          first;
    goal   = board.image_pixels();
    size   = (board.bpp_reg <= BPP_SMALL) ? 3 : 4;
    budget = $urandom_range(20, 120);
    sent   = 0;
    used   = 0;
    first  = 1'b1;
    while (sent < goal && used < budget) begin
      if ($urandom_range(0, 19) == 0) begin
        send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        used++;
      end
      hdr[7]   = 1'($urandom_range(0, 1));
      hdr[6:0] = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                             : 7'($urandom_range(0, 4));
      send_byte(hdr, first);
      first = 1'b0;
      used++;
      n_pix = hdr[7] ? 1 : int'(hdr[6:0]) + 1;
      for (int k = 0; k < n_pix && used < budget; k++) begin
        for (int j = 0; j < size; j++) begin
          send_byte(8'($urandom), 1'b0);
          used++;
        end
      end
      sent += int'(hdr[6:0]) + 1;
    end
    // trailing bytes past the image
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
    end
  endtask

  // result side
  initial begin
    result_t     got;
    int unsigned gap;
    bit          taken;
    pop = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = recv_idle ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop   = 1'b1;
      taken = 1'b0;
      while (!taken) begin
        @(posedge clk);
        if (!empty) begin
          taken           = 1'b1;
          got.pixel_value = pixel_value;
          got.run_length  = run_length;
          got.image_done  = image_done;
          got.run_clipped = run_clipped;
        end
        @(negedge clk);
      end
      board.check_result(got);
    end
  end

  // stimulus
  initial begin
    board       = new();
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_BPP;
    cfg_wdata   = '0;
    push        = 1'b0;
    data_byte   = '0;
    start_image = 1'b0;
    send_idle   = 1'b1;
    recv_idle   = 1'b1;
    items_sent  = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // repeat run longer than the image, clipped
    configure(3, 2, 1);
    send_byte(8'hff, 1'b1);
    repeat (3) send_byte(8'hff, 1'b0);
    // bytes after the image are dropped
    send_byte(8'h55, 1'b0);
    // raw pixel, then a repeat cut to the last pixel
    send_byte(8'h00, 1'b1);
    repeat (3) send_byte(8'h00, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'ha5, 1'b0);
    send_byte(8'h5a, 1'b0);
    send_byte(8'h01, 1'b0);
    // raw packet longer than the image
    send_byte(8'h7f, 1'b1);
    repeat (6) send_byte(8'($urandom), 1'b0);
    send_byte(8'h33, 1'b0);

    // pixel size changed halfway through a pixel
    configure(4, 2, 2);
    send_byte(8'h01, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    write_reg(CFG_BPP, CFG_DATA_W'(3));
    send_byte(8'h44, 1'b0);
    repeat (3) send_byte(8'($urandom), 1'b0);
    // image shrunk below the pixels already done
    configure(7, 1, 1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h12, 1'b0);

    // extreme settings, odd pixel sizes and empty images
    configure(4, 65535, 65535);
    repeat (2) send_image();
    configure(0, 65535, 1);
    repeat (2) send_image();
    configure(7, 1, 1);
    repeat (3) send_image();
    configure(3, 0, 4);
    repeat (2) send_image();
    configure(5, 3, 0);
    send_image();

    // random settings, mostly small images
    while (items_sent < ITEM_GOAL) begin
      configure($urandom_range(0, 7),
                ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 6),
                ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 6));
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 6)) begin
        if (items_sent < ITEM_GOAL) send_image();
      end
    end

    // drain and finish
    push = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (board.errors == 0) begin
      $display("tga_rle_pixel_decoder_tb passed");
    end else begin
      $display("tga_rle_pixel_decoder_tb failed");
    end
    $finish;
  end

endmodule
